FILE: src/cbb_pkg.sv
package cbb_pkg;

    localparam int unsigned MAX_NODES = 16;

    localparam int unsigned KIND_W   = 1;
    localparam int unsigned IDX_W    = 5;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned BASIS_W  = 17;
    localparam int unsigned ONE_Q16  = 65536;

    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_EVAL = 1'b1;

    localparam logic [1:0] REG_LOWER = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_NODES = 2'd2;

    // request as it sits in the queue between front and back
    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        knot_index;
        logic signed [VAL_W-1:0] value;
    } t_req;

    // saturate a signed sum to [0, 1.0] in Q1.16
    function automatic logic [BASIS_W-1:0] sat_unit(input logic signed [50:0] v);
        logic [BASIS_W-1:0] r;
        begin
            if (v < 0)
                r = '0;
            else if (v > 51'sd65536)
                r = BASIS_W'(ONE_Q16);
            else
                r = v[BASIS_W-1:0];
            return r;
        end
    endfunction

endpackage

FILE: src/cbb_front.sv
module cbb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic [cbb_pkg::IDX_W-1:0]     i_knot_index,
    input  logic signed [31:0]            i_knot_value,
    input  logic signed [31:0]            i_sample,
    input  logic signed [31:0]            i_lower,
    input  logic signed [31:0]            i_upper,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output cbb_pkg::t_req                 o_q_data
);
    // two-entry queue; evaluate requests carry the clamped sample
    cbb_pkg::t_req r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    cbb_pkg::t_req w_in;
    logic signed [31:0] w_eta;
    logic          w_push;

    // clamp: raise to lower first, then lower to upper
    always_comb begin
        w_eta = i_sample;
        if (w_eta < i_lower)
            w_eta = i_lower;
        if (w_eta > i_upper)
            w_eta = i_upper;
        w_in.kind       = i_kind;
        w_in.knot_index = i_knot_index;
        w_in.value      = (i_kind == cbb_pkg::KIND_EVAL) ? w_eta : i_knot_value;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push)
            r_mem[r_wp] <= w_in;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push)
                r_wp <= ~r_wp;
            if (i_q_pop)
                r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end
endmodule

FILE: src/cbb_div.sv
module cbb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [49:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [49:0] o_quo
);
    // restoring divider on magnitudes, one bit a cycle, truncates toward zero
    logic [49:0] r_q;
    logic [32:0] r_d;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_neg, r_busy;
    logic [33:0] w_sh;
    logic [33:0] w_sub;

    assign w_sh  = {r_rem[32:0], r_q[49]};
    assign w_sub = w_sh - {1'b0, r_d};
    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num[49] ? 50'(-i_num) : i_num;
                r_d    <= i_den[32] ? 33'(-i_den) : i_den;
                r_neg  <= i_num[49] ^ i_den[32];
                r_rem  <= '0;
                r_cnt  <= 6'd50;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!w_sub[33]) begin
                    r_rem <= w_sub;
                    r_q   <= {r_q[48:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q   <= {r_q[48:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: src/cbb_back.sv
module cbb_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    output logic                         o_q_pop,
    input  cbb_pkg::t_req                i_q_data,
    input  logic [4:0]                   i_node_count,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [cbb_pkg::IDX_W-1:0]    o_basis_index,
    output logic [cbb_pkg::BASIS_W-1:0]  o_basis_value,
    output logic                         o_last
);
    localparam int DEPTH = cbb_pkg::MAX_NODES + 6;
    localparam int KW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CALC = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // knot memory, one read port, registered data
    logic signed [31:0] r_knot [DEPTH];
    logic [KW-1:0]      r_raddr;
    logic signed [31:0] r_rdata;

    // basis working set, one row of flops per entry
    logic [cbb_pkg::BASIS_W-1:0] r_b [DEPTH];

    logic [2:0]  r_state;
    logic signed [31:0] r_eta;
    logic [4:0]  r_n;
    logic [4:0]  r_i;
    logic [1:0]  r_k;
    logic [1:0]  r_term;
    logic [2:0]  r_rd;
    logic signed [31:0] r_ka, r_kb, r_kc, r_kd;
    logic        r_found;
    logic signed [50:0] r_acc;
    logic        r_dstart;
    logic signed [49:0] r_dnum;
    logic signed [32:0] r_dden;
    logic        w_done;
    logic signed [49:0] w_quo;
    logic [4:0]  w_cnt;
    logic [4:0]  w_nsat;

    cbb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(r_dnum), .i_den(r_dden), .o_done(w_done), .o_quo(w_quo)
    );

    assign w_nsat  = (i_node_count < 5'd2) ? 5'd2 :
                     (i_node_count > 5'(cbb_pkg::MAX_NODES)) ? 5'(cbb_pkg::MAX_NODES) :
                     i_node_count;
    assign w_cnt   = r_n + 5'd5 - 5'(r_k);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_knot[r_raddr];
        if (o_q_pop && i_q_data.kind == cbb_pkg::KIND_LOAD
            && i_q_data.knot_index < 5'(DEPTH))
            r_knot[i_q_data.knot_index[KW-1:0]] <= i_q_data.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_valid  <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop && i_q_data.kind == cbb_pkg::KIND_EVAL) begin
                        r_eta   <= i_q_data.value;
                        r_n     <= w_nsat;
                        r_i     <= '0;
                        r_rd    <= 3'd0;
                        r_found <= 1'b0;
                        r_raddr <= '0;
                        for (int j = 0; j < DEPTH; j++)
                            r_b[j] <= '0;
                        r_state <= S_SRCH;
                    end
                end
                // interval search: knot i then knot i+1 each step
                S_SRCH: begin
                    r_rd <= r_rd + 3'd1;
                    if (r_rd == 3'd0) begin
                        r_raddr <= KW'(r_i + 5'd1);
                    end else if (r_rd == 3'd1) begin
                        r_ka <= r_rdata;
                    end else begin
                        r_rd <= 3'd0;
                        if (!r_found && r_ka <= r_eta && r_eta < r_rdata) begin
                            r_b[r_i[KW-1:0]] <= 17'(cbb_pkg::ONE_Q16);
                            r_found <= 1'b1;
                        end
                        if (r_i + 5'd1 == r_n + 5'd5) begin
                            r_k <= 2'd1;
                            r_i <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_i <= r_i + 5'd1;
                            r_raddr <= KW'(r_i + 5'd1);
                        end
                    end
                end
                // fetch t(i), t(i+1), t(i+k), t(i+k+1)
                S_RD: begin
                    r_rd <= r_rd + 3'd1;
                    case (r_rd)
                        3'd0: r_raddr <= KW'(r_i);
                        3'd1: r_raddr <= KW'(r_i + 5'd1);
                        3'd2: begin r_ka <= r_rdata; r_raddr <= KW'(r_i + 5'(r_k)); end
                        3'd3: begin r_kb <= r_rdata; r_raddr <= KW'(r_i + 5'(r_k) + 5'd1); end
                        3'd4: r_kc <= r_rdata;
                        default: begin
                            r_kd   <= r_rdata;
                            r_rd   <= 3'd0;
                            r_acc  <= '0;
                            r_term <= 2'd0;
                            r_state <= S_CALC;
                        end
                    endcase
                end
                // start up to two divisions, skip zero terms and zero-width spans, then store the saturated sum
                S_CALC: begin
                    if (r_term == 2'd2) begin
                        r_b[r_i[KW-1:0]] <= cbb_pkg::sat_unit(r_acc);
                        if (r_i + 5'd1 == w_cnt) begin
                            r_i <= '0;
                            if (r_k == 2'd3) begin
                                r_state <= S_OUT;
                                o_valid <= 1'b1;
                            end else begin
                                r_k <= r_k + 2'd1;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_i <= r_i + 5'd1;
                            r_state <= S_RD;
                        end
                    end else if (r_term == 2'd0) begin
                        if (r_b[r_i[KW-1:0]] == '0 || r_kc == r_ka) begin
                            r_term <= 2'd1;
                        end else begin
                            r_dnum <= 50'(($signed({1'b0, r_b[r_i[KW-1:0]]}))
                                      * (33'(r_eta) - 33'(r_ka)));
                            r_dden <= 33'(r_kc) - 33'(r_ka);
                            r_dstart <= 1'b1;
                            r_state <= S_WAIT;
                        end
                    end else begin
                        if (r_b[KW'(r_i + 5'd1)] == '0 || r_kd == r_kb) begin
                            r_term <= 2'd2;
                        end else begin
                            r_dnum <= 50'(($signed({1'b0, r_b[KW'(r_i + 5'd1)]}))
                                      * (33'(r_kd) - 33'(r_eta)));
                            r_dden <= 33'(r_kd) - 33'(r_kb);
                            r_dstart <= 1'b1;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_acc  <= r_acc + 51'(w_quo);
                        r_term <= r_term + 2'd1;
                        r_state <= S_CALC;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_i + 5'd1 == r_n + 5'd2) begin
                            o_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_basis_index = r_i;
    assign o_basis_value = r_b[r_i[KW-1:0]];
    assign o_last        = (r_i + 5'd1 == r_n + 5'd2);
endmodule

FILE: src/cubic_bspline_basis_eval.sv
// Cubic B-spline basis evaluator, Cox-de Boor recursion in fixed point.
// Slave stream takes requests: tuser = kind (0 load knot, 1 evaluate);
// tdata holds knot_index, knot_value, sample. A load writes one knot
// table entry and gives no result. An evaluate clamps the sample to
// [lower_bound, upper_bound] and produces n+2 results (n: node count held to
// [2, 16]) on the master stream: tdata = basis_index, basis_value (Q1.16);
// tlast marks the final value. Configuration is a plain write port, index 0 lower
// bound, 1 upper bound, 2 node count.
// A two-entry request queue separates the clamp front from the
// evaluation back end, so requests are taken while results wait.
// Per evaluate the back end searches the n+5 knot intervals, then per raised term
// fetches four knots and runs up to two divisions on the one shared divider,
// which holds the back end while it works; it then gives one result per cycle
// while the master is ready. The next request starts only after the last
// result of an evaluate is taken.
// Reset clears the control state; knot entries are undefined until loaded.
// A stalled master holds the current result and freezes the back end.
module cubic_bspline_basis_eval (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // knot_index[4:0], knot_value[36:5], sample[68:37]
    input  logic         s_axis_tuser,  // kind
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,  // basis_index[4:0], basis_value[21:5]
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    logic signed [31:0] r_lower, r_upper;
    logic [4:0]         r_nodes;
    logic               w_qv, w_pop;
    cbb_pkg::t_req      w_qd;
    logic [4:0]         w_bi;
    logic [16:0]        w_bv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= 32'sd65536;
            r_nodes <= 5'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cbb_pkg::REG_LOWER: r_lower <= i_cfg_data;
                cbb_pkg::REG_UPPER: r_upper <= i_cfg_data;
                cbb_pkg::REG_NODES: r_nodes <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    cbb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_kind(s_axis_tuser), .i_knot_index(s_axis_tdata[4:0]),
        .i_knot_value(s_axis_tdata[36:5]), .i_sample(s_axis_tdata[68:37]),
        .i_lower(r_lower), .i_upper(r_upper),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_qd)
    );

    cbb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_data(w_qd),
        .i_node_count(r_nodes),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_basis_index(w_bi), .o_basis_value(w_bv), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_bv, w_bi};

    // basis values never exceed one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_bv <= 17'd65536))
        else $error("basis value above one");

    // a stalled result holds its index
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(w_bi))
        else $error("result index moved under stall");

    // results are not produced while the queue is popped
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !m_axis_tvalid)
        else $error("queue pop during result output");
endmodule
